[hdl/price_level_book_update_defines.svh]
// Assertion macros for the price level book update checker.
// No dependencies; included by the checker file only.
`ifndef PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH
`define PRICE_LEVEL_BOOK_UPDATE_DEFINES_SVH

// same-cycle implication, clocked on clk, off during reset
`define PLBU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define PLBU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/plbu_pkg.sv]
// Shared constants, types and codes for the price level book update block.
// No dependencies; used by every module of the block.
`default_nettype none

package plbu_pkg;

    localparam int MAX_LEVELS = 32;
    localparam int CNT_W      = $clog2(MAX_LEVELS + 1);
    localparam int PRICE_W    = 32;
    localparam int QTY_W      = 32;
    localparam int USED_W     = 6;
    localparam int MID_W      = PRICE_W + 1;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = PRICE_W + QTY_W;
    localparam int OUT_DATA_W = 3 + 2 * (PRICE_W + QTY_W) + MID_W + 2 * USED_W;

    typedef logic [1:0] op_t;
    localparam op_t OP_HOLD = 2'd0;
    localparam op_t OP_QTY  = 2'd1;
    localparam op_t OP_DEL  = 2'd2;
    localparam op_t OP_INS  = 2'd3;

    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_APPLIED = 2'd0;
    localparam status_t ST_NOOP    = 2'd1;
    localparam status_t ST_DROP    = 2'd2;

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [QTY_W-1:0]   qty;
    } level_t;

    typedef struct packed {
        logic capture;
        op_t  op;
    } cell_cmd_t;

    typedef struct packed {
        logic sel;
        logic capture;
        logic apply;
    } side_ctl_t;

endpackage

`default_nettype wire

[hdl/plbu_cell.sv]
// One level cell of a side's sorted chain: holds a price and quantity,
// compares against the update and shifts with its neighbours. Uses plbu_pkg.
`default_nettype none

module plbu_cell (
    input  wire                           clk,
    input  wire                           is_ask,
    input  wire                           valid,
    input  plbu_pkg::level_t              upd,
    input  plbu_pkg::cell_cmd_t           cmd,
    input  wire                           prev_b,
    input  plbu_pkg::level_t              left,
    input  plbu_pkg::level_t              right,
    output plbu_pkg::level_t              lvl,
    output plbu_pkg::level_t              lvl_nx,
    output logic                          b,
    output logic                          hit
);

    plbu_pkg::level_t lvl_reg;
    plbu_pkg::level_t lvl_next;
    logic             b_reg;
    logic             eq_reg;
    logic             better;
    logic             first;

    // held level ranks ahead of the update (best-first order)
    assign better = is_ask ? (lvl_reg.price < upd.price) : (lvl_reg.price > upd.price);
    assign first  = !b_reg && prev_b;

    always_comb
    begin
        lvl_next = lvl_reg;
        unique case (cmd.op)
            plbu_pkg::OP_QTY:
            begin
                if (first && eq_reg)
                    lvl_next.qty = upd.qty;
            end
            plbu_pkg::OP_DEL:
            begin
                if (!b_reg)
                    lvl_next = right;
            end
            plbu_pkg::OP_INS:
            begin
                if (!b_reg)
                    lvl_next = prev_b ? upd : left;
            end
            default:
            begin
                lvl_next = lvl_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            b_reg  <= valid && better;
            eq_reg <= valid && (lvl_reg.price == upd.price);
        end
        lvl_reg <= lvl_next;
    end

    assign lvl    = lvl_reg;
    assign lvl_nx = lvl_next;
    assign b      = b_reg;
    assign hit    = first && eq_reg;

endmodule

`default_nettype wire

[hdl/plbu_side.sv]
// One book side: a best-first chain of plbu_cell instances, the level count
// and the update decision. Uses plbu_pkg and plbu_cell.
`default_nettype none

module plbu_side (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           is_ask,
    input  plbu_pkg::side_ctl_t           ctl,
    input  plbu_pkg::level_t              upd,
    output plbu_pkg::status_t             status,
    output logic [plbu_pkg::CNT_W-1:0]    count_next,
    output plbu_pkg::level_t              best_next
);

    localparam int N = plbu_pkg::MAX_LEVELS;

    logic [plbu_pkg::CNT_W-1:0] count_reg;
    logic [N-1:0]               b_vec;
    logic [N-1:0]               hit_vec;
    plbu_pkg::level_t           lvl_arr [N];
    plbu_pkg::level_t           nx_arr  [N];
    plbu_pkg::op_t              op;
    plbu_pkg::cell_cmd_t        cmd;
    logic                       found;
    logic                       full;
    logic                       qz;

    assign found = |hit_vec;
    assign full  = count_reg == plbu_pkg::CNT_W'(N);
    assign qz    = upd.qty == '0;

    always_comb
    begin
        if (found)
        begin
            op     = qz ? plbu_pkg::OP_DEL : plbu_pkg::OP_QTY;
            status = plbu_pkg::ST_APPLIED;
        end
        else if (qz)
        begin
            op     = plbu_pkg::OP_HOLD;
            status = plbu_pkg::ST_NOOP;
        end
        else if (full && b_vec[N-1])
        begin
            op     = plbu_pkg::OP_HOLD;
            status = plbu_pkg::ST_DROP;
        end
        else
        begin
            op     = plbu_pkg::OP_INS;
            status = plbu_pkg::ST_APPLIED;
        end
    end

    assign cmd.capture = ctl.sel && ctl.capture;
    assign cmd.op      = (ctl.sel && ctl.apply) ? op : plbu_pkg::OP_HOLD;

    always_comb
    begin
        count_next = count_reg;
        if (cmd.op == plbu_pkg::OP_DEL)
            count_next = count_reg - plbu_pkg::CNT_W'(1);
        else if (cmd.op == plbu_pkg::OP_INS && !full)
            count_next = count_reg + plbu_pkg::CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            logic             prev_b;
            plbu_pkg::level_t left;
            plbu_pkg::level_t right;

            if (i == 0)
            begin : g_head
                assign prev_b = 1'b1;
                assign left   = '0;
            end
            else
            begin : g_body
                assign prev_b = b_vec[i-1];
                assign left   = lvl_arr[i-1];
            end

            if (i == N - 1)
            begin : g_tail
                assign right = '0;
            end
            else
            begin : g_mid
                assign right = lvl_arr[i+1];
            end

            plbu_cell u_cell (
                .clk    (clk),
                .is_ask (is_ask),
                .valid  (plbu_pkg::CNT_W'(i) < count_reg),
                .upd    (upd),
                .cmd    (cmd),
                .prev_b (prev_b),
                .left   (left),
                .right  (right),
                .lvl    (lvl_arr[i]),
                .lvl_nx (nx_arr[i]),
                .b      (b_vec[i]),
                .hit    (hit_vec[i])
            );
        end
    endgenerate

    assign best_next = nx_arr[0];

endmodule

`default_nettype wire

[hdl/price_level_book_update.sv]
// Top level of the price level book update block: input capture, sequencing,
// the two book sides and the result register. Uses plbu_pkg and plbu_side.
//
// Input channel s_*: one level update per transfer (side in tuser, price and
// quantity in tdata). Output channel m_*: one result per update, giving the
// status and the top of the book after the update.
// Each side is a best-first chain of MAX_LEVELS cells. After its transfer an
// update passes through S_CMP, which registers every cell's compare against
// the new price, and then S_APPLY, which shifts or rewrites the cells in
// parallel and loads the result register. The next update is taken in the
// cycle that loads that result and not before, so a new update is taken only
// as the last one completes.
// The result register holds one result. While the receiver stalls with a
// result pending, the next update waits in its apply cycle and s_tready
// stays low, so nothing is lost.
// Reset empties both sides (level counts to zero) and clears m_tvalid; the
// block is ready for an update as soon as reset is released.
`default_nettype none

module price_level_book_update (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // [31:0] price, [63:32] quantity
    input  wire  [plbu_pkg::IN_DATA_W-1:0]      s_tdata,
    // [0] side
    input  wire                                 s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [0] best_bid_valid, [32:1] best_bid_price, [64:33] best_bid_qty,
    // [65] best_ask_valid, [97:66] best_ask_price, [129:98] best_ask_qty,
    // [130] mid_valid, [163:131] mid_twice, [169:164] bid_levels_used,
    // [175:170] ask_levels_used
    output logic [plbu_pkg::OUT_DATA_W-1:0]     m_tdata,
    // [1:0] status
    output logic [plbu_pkg::STATUS_W-1:0]       m_tuser
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic                             side_reg;
    plbu_pkg::level_t                 upd_reg;
    logic                             m_tvalid_reg;
    logic [plbu_pkg::OUT_DATA_W-1:0]  m_tdata_reg;
    plbu_pkg::status_t                m_tuser_reg;

    logic                             accept;
    logic                             apply_fire;
    plbu_pkg::side_ctl_t              bid_ctl;
    plbu_pkg::side_ctl_t              ask_ctl;
    plbu_pkg::status_t                bid_status;
    plbu_pkg::status_t                ask_status;
    logic [plbu_pkg::CNT_W-1:0]       bid_cnt;
    logic [plbu_pkg::CNT_W-1:0]       ask_cnt;
    plbu_pkg::level_t                 bid_best;
    plbu_pkg::level_t                 ask_best;
    logic                             bv;
    logic                             av;
    logic                             mv;
    logic [plbu_pkg::PRICE_W-1:0]     bp;
    logic [plbu_pkg::QTY_W-1:0]       bq;
    logic [plbu_pkg::PRICE_W-1:0]     ap;
    logic [plbu_pkg::QTY_W-1:0]       aq;
    logic [plbu_pkg::MID_W-1:0]       mid;

    assign apply_fire = (state_reg == S_APPLY) && (!m_tvalid_reg || m_tready);
    assign s_tready   = (state_reg == S_IDLE) || apply_fire;
    assign accept     = s_tvalid && s_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                if (apply_fire)
                    state_next = accept ? S_CMP : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            side_reg      <= s_tuser;
            upd_reg.price <= s_tdata[plbu_pkg::PRICE_W-1:0];
            upd_reg.qty   <= s_tdata[plbu_pkg::IN_DATA_W-1:plbu_pkg::PRICE_W];
        end
    end

    assign bid_ctl.sel     = !side_reg;
    assign bid_ctl.capture = state_reg == S_CMP;
    assign bid_ctl.apply   = apply_fire;
    assign ask_ctl.sel     = side_reg;
    assign ask_ctl.capture = state_reg == S_CMP;
    assign ask_ctl.apply   = apply_fire;

    plbu_side u_bid (
        .clk        (clk),
        .rst_n      (rst_n),
        .is_ask     (1'b0),
        .ctl        (bid_ctl),
        .upd        (upd_reg),
        .status     (bid_status),
        .count_next (bid_cnt),
        .best_next  (bid_best)
    );

    plbu_side u_ask (
        .clk        (clk),
        .rst_n      (rst_n),
        .is_ask     (1'b1),
        .ctl        (ask_ctl),
        .upd        (upd_reg),
        .status     (ask_status),
        .count_next (ask_cnt),
        .best_next  (ask_best)
    );

    // the untouched side holds, so its next values equal its current ones
    assign bv  = bid_cnt != '0;
    assign av  = ask_cnt != '0;
    assign mv  = bv && av;
    assign bp  = bv ? bid_best.price : '0;
    assign bq  = bv ? bid_best.qty   : '0;
    assign ap  = av ? ask_best.price : '0;
    assign aq  = av ? ask_best.qty   : '0;
    assign mid = mv ? ({1'b0, bp} + {1'b0, ap}) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (apply_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (apply_fire)
        begin
            m_tuser_reg <= side_reg ? ask_status : bid_status;
            m_tdata_reg <= {plbu_pkg::USED_W'(ask_cnt), plbu_pkg::USED_W'(bid_cnt),
                            mid, mv, aq, ap, av, bq, bp, bv};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

[hdl/plbu_checker.sv]
// Port-level checks for price_level_book_update, attached by bind.
// Depends on plbu_pkg and price_level_book_update_defines.svh.
`default_nettype none
`include "price_level_book_update_defines.svh"

module plbu_checker (
    input wire                               clk,
    input wire                               rst_n,
    input wire                               s_tvalid,
    input wire                               s_tready,
    input wire                               m_tvalid,
    input wire                               m_tready,
    input wire [plbu_pkg::OUT_DATA_W-1:0]    m_tdata,
    input wire [plbu_pkg::STATUS_W-1:0]      m_tuser
);

    logic                         in_xfer;
    logic                         bv;
    logic                         av;
    logic                         mv;
    logic [plbu_pkg::PRICE_W-1:0] bp;
    logic [plbu_pkg::QTY_W-1:0]   bq;
    logic [plbu_pkg::PRICE_W-1:0] ap;
    logic [plbu_pkg::MID_W-1:0]   mid;
    logic [plbu_pkg::MID_W-1:0]   mid_sum;

    assign in_xfer = s_tvalid && s_tready;
    assign bv      = m_tdata[0];
    assign bp      = m_tdata[32:1];
    assign bq      = m_tdata[64:33];
    assign av      = m_tdata[65];
    assign ap      = m_tdata[97:66];
    assign mv      = m_tdata[130];
    assign mid     = m_tdata[163:131];
    assign mid_sum = {1'b0, bp} + {1'b0, ap};

    `PLBU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
    `PLBU_ASSERT_NEXT(a_busy_after_xfer, in_xfer, !s_tready, "input taken in compare cycle")
    `PLBU_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= plbu_pkg::ST_DROP, "undefined status code")
    `PLBU_ASSERT_NOW(a_mid, m_tvalid, (mv == (bv && av)) && (mv ? (mid == mid_sum) : (mid == '0)), "mid price inconsistent with best levels")
    `PLBU_ASSERT_NOW(a_empty_bid, m_tvalid && !bv, (bp == '0) && (bq == '0), "empty bid side shows a level")

endmodule

bind price_level_book_update plbu_checker u_plbu_checker (.*);

`default_nettype wire
